@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SFR_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sfr_pkg.sv @@
package sfr_pkg;

  // Longest pattern and longest replacement text, in bytes.
  localparam int unsigned MAX_PATTERN = 8;
  localparam int unsigned MAX_REPLACE = 8;

  // One item can produce a replacement or plain byte, a flushed tail and a terminator.
  localparam int unsigned JOB_BYTES = 9;

  // Depth of the job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SEARCH_PATTERN = 3'd0;
  localparam logic [2:0] CFG_SEARCH_LENGTH  = 3'd1;
  localparam logic [2:0] CFG_REPLACE_TEXT   = 3'd2;
  localparam logic [2:0] CFG_REPLACE_LENGTH = 3'd3;
  localparam logic [2:0] CFG_OUTPUT_LIMIT   = 3'd4;

  // Configuration as seen by the front end.
  typedef struct packed {
    logic [7:0][7:0] search_pattern;
    logic [3:0]      search_length;
    logic [7:0][7:0] replace_text;
    logic [3:0]      replace_length;
    logic [15:0]     output_limit;
  } cfg_t;

  // Output work for one item: bytes in emission order, count and terminator flag.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [3:0]                count;
    logic                      term;
  } job_t;

endpackage

@@ hw/rtl/stream_find_and_replace.sv @@
// Streaming find-and-replace: bytes of a string enter on the in_ channel, one item per
// cycle while the queue has room, and every non-overlapping left-to-right occurrence of
// the configured pattern is replaced by the configured text, with output cut off at the
// output limit; a terminator item follows the last input byte. The front end decides
// each input item combinationally and writes its results as one job into a two-entry
// queue; the back end plays a job out at one result per cycle while out_ready is high and
// sets the sustained rate, up to nine results per item. Configuration registers are to be
// written through the cfg_ port by the user only while idle; the block does not enforce it.
module stream_find_and_replace (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_terminator,
  output logic        out_run_last
);
  import sfr_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  job_t push_job, head_job;
  logic q_ready, q_push, head_valid, pop;

  // Configuration register writes; indexes beyond the list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SEARCH_PATTERN: cfg_nxt.search_pattern = cfg_wdata;
        CFG_SEARCH_LENGTH:  cfg_nxt.search_length  = cfg_wdata[3:0];
        CFG_REPLACE_TEXT:   cfg_nxt.replace_text   = cfg_wdata;
        CFG_REPLACE_LENGTH: cfg_nxt.replace_length = cfg_wdata[3:0];
        CFG_OUTPUT_LIMIT:   cfg_nxt.output_limit   = cfg_wdata[15:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.search_pattern <= '0;
      cfg_r.search_length  <= 4'd1;
      cfg_r.replace_text   <= '0;
      cfg_r.replace_length <= 4'd0;
      cfg_r.output_limit   <= 16'hFFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  sfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_ready),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid)
  );

  sfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_job          (head_job),
    .head_valid        (head_valid),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_is_terminator (out_is_terminator),
    .out_run_last      (out_run_last)
  );

endmodule

@@ hw/rtl/sfr_front.sv @@
module sfr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  sfr_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          q_ready,
  output logic          q_push,
  output sfr_pkg::job_t q_job
);
  import sfr_pkg::*;

  logic [7:0][7:0] win_r, win_nxt;
  logic [3:0]      fill_r, fill_nxt;
  logic [3:0]      active_r, active_nxt;
  logic [15:0]     wcount_r, wcount_nxt;
  logic            stop_r, stop_nxt;

  logic            accept;
  logic [3:0]      eff_len, rl_eff, act;
  logic [7:0][7:0] w1, w2, prim;
  logic [3:0]      fill1, fill2, pcnt, nflush, ii, jj;
  logic [15:0]     wc2, room;
  logic            stop2, match;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  // Clamp the configured lengths to their legal ranges.
  always_comb begin
    eff_len = cfg.search_length;
    if (eff_len == 4'd0) begin
      eff_len = 4'd1;
    end else if (eff_len > 4'(MAX_PATTERN)) begin
      eff_len = 4'(MAX_PATTERN);
    end
    rl_eff = (cfg.replace_length > 4'(MAX_REPLACE)) ? 4'(MAX_REPLACE) : cfg.replace_length;
  end

  // Classify the incoming byte: match, plain byte, stop, and the tail flush on the last item.
  always_comb begin
    act   = (fill_r == 4'd0) ? eff_len : active_r;
    w1    = win_r;
    fill1 = fill_r;
    if (!stop_r && fill_r < 4'(MAX_PATTERN)) begin
      w1[fill_r[2:0]] = in_byte;
      fill1           = fill_r + 4'd1;
    end

    match = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (4'(k) < act && w1[k] != cfg.search_pattern[k]) begin
        match = 1'b0;
      end
    end

    prim  = '0;
    pcnt  = 4'd0;
    wc2   = wcount_r;
    stop2 = stop_r;
    w2    = w1;
    fill2 = fill1;
    if (!stop_r && fill1 >= act) begin
      if (match) begin
        if (17'(wcount_r) + 17'(rl_eff) > 17'(cfg.output_limit)) begin
          stop2 = 1'b1;
        end else begin
          prim = cfg.replace_text;
          pcnt = rl_eff;
          wc2  = wcount_r + 16'(rl_eff);
        end
        fill2 = 4'd0;
      end else begin
        if (wcount_r >= cfg.output_limit) begin
          stop2 = 1'b1;
        end else begin
          prim[0] = w1[0];
          pcnt    = 4'd1;
          wc2     = wcount_r + 16'd1;
        end
        w2    = w1 >> 8;
        fill2 = fill1 - 4'd1;
      end
    end
    if (stop2) begin
      fill2 = 4'd0;
    end

    // The tail is written only as far as the limit allows.
    room   = (cfg.output_limit > wc2) ? (cfg.output_limit - wc2) : 16'd0;
    nflush = 4'd0;
    if (in_last) begin
      nflush = (room < 16'(fill2)) ? room[3:0] : fill2;
    end
  end

  // Pack the result bytes of this item into one job.
  always_comb begin
    q_job = '0;
    ii    = 4'd0;
    jj    = 4'd0;
    for (int i = 0; i < JOB_BYTES; i++) begin
      ii = 4'(i);
      jj = ii - pcnt;
      if (ii < pcnt) begin
        q_job.bytes[i] = prim[ii[2:0]];
      end else if (jj < nflush) begin
        q_job.bytes[i] = w2[jj[2:0]];
      end
    end
    q_job.count = pcnt + nflush + {3'd0, in_last};
    q_job.term  = in_last;
    q_push      = accept && (q_job.count != 4'd0);
  end

  // State update; the end of a string returns the stream state to its start.
  always_comb begin
    win_nxt    = win_r;
    fill_nxt   = fill_r;
    active_nxt = active_r;
    wcount_nxt = wcount_r;
    stop_nxt   = stop_r;
    if (accept) begin
      win_nxt    = w2;
      active_nxt = act;
      fill_nxt   = in_last ? 4'd0 : fill2;
      wcount_nxt = in_last ? 16'd0 : wc2;
      stop_nxt   = in_last ? 1'b0 : stop2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= 4'd0;
      active_r <= 4'd1;
      wcount_r <= 16'd0;
      stop_r   <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      active_r <= active_nxt;
      wcount_r <= wcount_nxt;
      stop_r   <= stop_nxt;
    end
  end

  // The window itself needs no reset: only filled entries are read.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

@@ hw/rtl/sfr_queue.sv @@
module sfr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfr_pkg::job_t push_job,
  output logic          push_ready,
  input  logic          pop,
  output sfr_pkg::job_t head_job,
  output logic          head_valid
);
  import sfr_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rptr_r];

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

endmodule

@@ hw/rtl/sfr_back.sv @@
module sfr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  sfr_pkg::job_t head_job,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_is_terminator,
  output logic          out_run_last
);
  import sfr_pkg::*;

  job_t       cur_r, cur_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       last_b, done;

  // The current job is played out one byte per accepted item.
  assign last_b            = (idx_r == cur_r.count - 4'd1);
  assign done              = busy_r && out_ready && last_b;
  assign pop               = head_valid && (!busy_r || done);
  assign out_valid         = busy_r;
  assign out_byte          = cur_r.bytes[idx_r];
  assign out_is_terminator = cur_r.term && last_b;
  assign out_run_last      = last_b;

  // Load the next job as the current one finishes, without a gap.
  always_comb begin
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (pop) begin
      cur_nxt  = head_job;
      idx_nxt  = 4'd0;
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && out_ready) begin
      idx_nxt = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 4'd0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

@@ hw/rtl/sfr_checker.sv @@
`include "assert_macros.svh"

module sfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_is_terminator,
  input logic       out_run_last
);

  // A result offered but not taken stays offered and unchanged.
  `SFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_byte), "result dropped or changed while waiting")

  // The terminator carries a zero byte and closes the results of its item.
  `SFR_ASSERT_NOW(a_term_form, out_valid && out_is_terminator,
                  out_byte == 8'd0 && out_run_last, "terminator malformed")

  // The results of one item leave back to back: no gap inside a run.
  `SFR_ASSERT_NEXT(a_run_contiguous, out_valid && out_ready && !out_run_last, out_valid,
                   "gap inside a run")

  // Reset empties the output side.
  `SFR_ASSERT_ALWAYS_NEXT(a_reset_empty, !rst_n, !out_valid, "output valid after reset")

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_byte          (out_byte),
  .out_is_terminator (out_is_terminator),
  .out_run_last      (out_run_last)
);

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import sfr_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 285;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned END_CYCLES     = 20;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DIRECTED_ROWS  = 40;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: a register write or an input item, with an
  // optional hand-written result count and first character.
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [63:0] reg_val;
    logic [7:0]  ch;
    logic        is_last;
    logic        pinned;
    logic [3:0]  n_pin;
    logic [7:0]  first_pin;
  } step_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       term;
    logic       run_last;
  } res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_is_terminator;
  logic        out_run_last;

  // Register copies used by the predictor, at their reset values.
  logic [63:0] pattern_r = '0;
  logic [3:0]  slen_r    = 4'd1;
  logic [63:0] text_r    = '0;
  logic [3:0]  rlen_r    = 4'd0;
  logic [15:0] limit_r   = 16'hFFFF;

  // Predictor state.
  logic [7:0]  win_bytes [8];
  int unsigned win_fill      = 0;
  int unsigned active_len    = 1;
  int unsigned bytes_written = 0;
  bit          out_halted    = 1'b0;

  res_t step_chars[$];
  res_t pending_chars[$];

  int unsigned errors       = 0;
  int unsigned items_in     = 0;
  int unsigned results_out  = 0;
  int unsigned strings_done = 0;
  int unsigned settings_used = 0;
  bit          no_idling    = 1'b0;
  bit          hold_output  = 1'b0;

  step_row_t directed_rows [DIRECTED_ROWS] = '{
    // Reset settings: one-byte zero pattern, empty replacement.
    '{ROW_ITEM, '0, '0, 8'h41, 1'b1, 1'b1, 4'd2, 8'h41},
    '{ROW_ITEM, '0, '0, 8'h00, 1'b0, 1'b1, 4'd0, 8'h00},
    '{ROW_ITEM, '0, '0, 8'hFF, 1'b1, 1'b1, 4'd2, 8'hFF},
    // Two-byte pattern replaced by three bytes.
    '{ROW_CFG, CFG_SEARCH_PATTERN, 64'h6261, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_SEARCH_LENGTH, 64'd2, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_REPLACE_TEXT, 64'h5A5958, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_REPLACE_LENGTH, 64'd3, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h61, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h61, 1'b0, 1'b1, 4'd1, 8'h61},
    '{ROW_ITEM, '0, '0, 8'h62, 1'b1, 1'b1, 4'd4, 8'h58},
    // Oversized lengths clip to eight: a full match plus terminator.
    '{ROW_CFG, CFG_SEARCH_PATTERN, 64'h0102_0408_1020_4080, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_SEARCH_LENGTH, 64'd15, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_REPLACE_TEXT, 64'hFEFD_FBF7_EFDF_BF7F, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_REPLACE_LENGTH, 64'd15, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h80, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h40, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h20, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h10, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h08, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h04, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h02, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h01, 1'b1, 1'b1, 4'd9, 8'h7F},
    // Pattern length changed while the window holds bytes.
    '{ROW_ITEM, '0, '0, 8'h80, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_SEARCH_LENGTH, 64'd2, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h40, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h55, 1'b1, 1'b0, '0, '0},
    // Zero length acts as one; a zero limit stops the first plain byte.
    '{ROW_CFG, CFG_SEARCH_LENGTH, 64'd0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_OUTPUT_LIMIT, 64'd0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h71, 1'b1, 1'b1, 4'd1, 8'h00},
    // Replacement that does not fit, then bytes dropped until the end.
    '{ROW_CFG, CFG_SEARCH_LENGTH, 64'd2, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_OUTPUT_LIMIT, 64'd8, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h33, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h80, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h40, 1'b0, 1'b1, 4'd0, 8'h00},
    '{ROW_ITEM, '0, '0, 8'h11, 1'b1, 1'b1, 4'd1, 8'h00},
    // Limit lowered below the count in the middle of a string.
    '{ROW_CFG, CFG_OUTPUT_LIMIT, 64'd65535, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h61, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h62, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_OUTPUT_LIMIT, 64'd0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h63, 1'b1, 1'b1, 4'd1, 8'h00}
  };

  stream_find_and_replace dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_is_terminator (out_is_terminator),
    .out_run_last      (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_error(string msg);
    errors++;
    if (errors <= 50) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic void queue_char(logic [7:0] ch, logic term);
    res_t r;
    r.ch       = ch;
    r.term     = term;
    r.run_last = 1'b0;
    step_chars.push_back(r);
  endfunction

  // A plain byte is written only while output runs and the count is below the limit.
  function automatic void write_plain(logic [7:0] ch);
    if (out_halted) return;
    if (bytes_written >= limit_r) begin
      out_halted = 1'b1;
      return;
    end
    queue_char(ch, 1'b0);
    bytes_written = (bytes_written + 1) & 32'hFFFF;
  endfunction

  // Works out the characters that one input item produces and queues them.
  function automatic void replace_step(logic [7:0] ch, logic is_last);
    int unsigned rl;
    bit          hit;
    res_t        r;
    step_chars.delete();
    if (win_fill == 0) begin
      active_len = (slen_r == 0) ? 1 : ((slen_r > MAX_PATTERN) ? MAX_PATTERN : slen_r);
    end
    if (!out_halted && win_fill < 8) begin
      win_bytes[win_fill] = ch;
      win_fill++;
    end
    if (!out_halted && win_fill >= active_len) begin
      hit = 1'b1;
      for (int k = 0; k < active_len; k++) begin
        if (win_bytes[k] != pattern_r[8*k +: 8]) hit = 1'b0;
      end
      if (hit) begin
        rl = (rlen_r > MAX_REPLACE) ? MAX_REPLACE : rlen_r;
        if (bytes_written + rl > limit_r) begin
          out_halted = 1'b1;
        end else begin
          for (int k = 0; k < rl; k++) queue_char(text_r[8*k +: 8], 1'b0);
          bytes_written = (bytes_written + rl) & 32'hFFFF;
        end
        win_fill = 0;
      end else begin
        write_plain(win_bytes[0]);
        for (int k = 0; k < 7; k++) win_bytes[k] = win_bytes[k+1];
        win_fill--;
      end
    end
    if (out_halted) win_fill = 0;
    // End of string: flush the short tail, then the terminator.
    if (is_last) begin
      for (int k = 0; k < win_fill; k++) write_plain(win_bytes[k]);
      queue_char(8'h00, 1'b1);
      win_fill      = 0;
      bytes_written = 0;
      out_halted    = 1'b0;
    end
    if (step_chars.size() > 0) begin
      r          = step_chars.pop_back();
      r.run_last = 1'b1;
      step_chars.push_back(r);
    end
    foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_SEARCH_PATTERN: pattern_r = val;
      CFG_SEARCH_LENGTH:  slen_r    = val[3:0];
      CFG_REPLACE_TEXT:   text_r    = val;
      CFG_REPLACE_LENGTH: rlen_r    = val[3:0];
      CFG_OUTPUT_LIMIT:   limit_r   = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offers one item and holds it until the block takes it.
  task automatic send_char(logic [7:0] ch, logic is_last);
    in_valid <= 1'b1;
    in_byte  <= ch;
    in_last  <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_in++;
    replace_step(ch, is_last);
  endtask

  task automatic idle_in(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_idle_in();
    if (!no_idling && $urandom_range(0, 5) == 0) idle_in($urandom_range(1, 11));
  endtask

  // Waits for every expected character, then lets the front end settle.
  task automatic drain_pending();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: compare each accepted item with the oldest expectation.
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_out++;
      if (pending_chars.size() == 0) begin
        report_error($sformatf("result %02h with nothing expected", out_byte));
      end else begin
        want = pending_chars.pop_front();
        if (out_byte !== want.ch)
          report_error($sformatf("out_byte %02h, expected %02h", out_byte, want.ch));
        if (out_is_terminator !== want.term)
          report_error($sformatf("out_is_terminator %b, expected %b",
                                 out_is_terminator, want.term));
        if (out_run_last !== want.run_last)
          report_error($sformatf("out_run_last %b, expected %b",
                                 out_run_last, want.run_last));
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request, none near the end.
  initial begin : receiver
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else if (!no_idling && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) begin
          @(posedge clk);
          if (hold_output) break;
        end
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    step_row_t   row;
    int unsigned rand_items;
    int unsigned phase;
    int unsigned target;
    int unsigned pick;
    int unsigned cut;
    int unsigned eff;
    logic [7:0]  str_q[$];
    logic [63:0] pat;
    logic [3:0]  slen_pick;
    logic [3:0]  rlen_pick;
    logic [15:0] lim_pick;
    bit          low_alpha;

    rand_items = 0;
    phase      = 0;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_SEARCH_PATTERN;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_byte   <= '0;
    in_last   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; pinned rows cross-check the predictor by hand.
    settings_used = 1;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        if (r > 0 && directed_rows[r-1].kind == ROW_ITEM) drain_pending();
        write_reg(row.reg_idx, row.reg_val);
        settings_used++;
      end else begin
        maybe_idle_in();
        send_char(row.ch, row.is_last);
        if (row.is_last) strings_done++;
        if (row.pinned && step_chars.size() != row.n_pin)
          report_error($sformatf("row %0d gives %0d results, table says %0d",
                                 r, step_chars.size(), row.n_pin));
        else if (row.pinned && row.n_pin != 0 && step_chars[0].ch != row.first_pin)
          report_error($sformatf("row %0d first result %02h, table says %02h",
                                 r, step_chars[0].ch, row.first_pin));
      end
    end

    // Random phases: a fresh setting, then a few strings built around the pattern.
    while (rand_items < RANDOM_ITEMS) begin
      drain_pending();
      low_alpha = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < 8; k++) begin
        pat[8*k +: 8] = low_alpha ? 8'(8'h41 + $urandom_range(0, 1))
                                  : 8'($urandom_range(1, 255));
      end
      if ($urandom_range(0, 9) == 0)
        slen_pick = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
      else
        slen_pick = 4'($urandom_range(1, 8));
      rlen_pick = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
      case ($urandom_range(0, 9))
        0, 1:    lim_pick = 16'($urandom_range(0, 20));
        2:       lim_pick = 16'hFFFF;
        default: lim_pick = 16'($urandom_range(21, 65534));
      endcase
      // The held phase runs with an open limit so that results pile up.
      if (phase == 2) lim_pick = 16'hFFFF;
      write_reg(CFG_SEARCH_PATTERN, pat);
      write_reg(CFG_SEARCH_LENGTH, {60'd0, slen_pick});
      write_reg(CFG_REPLACE_TEXT, {$urandom, $urandom});
      write_reg(CFG_REPLACE_LENGTH, {60'd0, rlen_pick});
      write_reg(CFG_OUTPUT_LIMIT, {48'd0, lim_pick});
      settings_used++;
      // The output side backs up once while input keeps coming.
      if (phase == 2) hold_output = 1'b1;
      if (rand_items + 50 >= RANDOM_ITEMS) no_idling = 1'b1;
      eff = (slen_r == 0) ? 1 : ((slen_r > MAX_PATTERN) ? MAX_PATTERN : slen_r);

      // Long strings in the held phase keep the sender offering items throughout.
      repeat ((phase == 2) ? 4 : $urandom_range(1, 4)) begin
        str_q.delete();
        target = (phase == 2) ? $urandom_range(16, 24) : $urandom_range(1, 24);
        while (str_q.size() < target) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            for (int k = 0; k < eff; k++) str_q.push_back(pattern_r[8*k +: 8]);
          end else if (pick < 6) begin
            cut = $urandom_range(1, eff);
            for (int k = 0; k < cut; k++) str_q.push_back(pattern_r[8*k +: 8]);
          end else if (pick < 8) begin
            str_q.push_back(pattern_r[8*$urandom_range(0, eff - 1) +: 8]);
          end else begin
            str_q.push_back(8'($urandom_range(1, 255)));
          end
        end
        foreach (str_q[i]) begin
          maybe_idle_in();
          send_char(str_q[i], i == str_q.size() - 1);
          rand_items++;
        end
        strings_done++;
      end
      phase++;
    end

    drain_pending();
    repeat (END_CYCLES) @(posedge clk);
    $display("Run covered %0d input items and %0d result items in %0d strings.",
             items_in, results_out, strings_done);
    $display("Register settings applied: %0d, including clipped lengths and zero limits.",
             settings_used);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
